[hdl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RCHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RCHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/rchp_pkg.sv]
`default_nettype none
package rchp_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned WidthBits   = 31;
   localparam int unsigned DivCells    = 31;
   localparam int unsigned CordicSteps = 30;
   localparam int unsigned CordicWidth = 34;

   localparam logic [CordicWidth-1:0] CordicX0 = 34'd652032874;
   localparam logic signed [CordicWidth-1:0] OneQ30 = 34'sd1073741824;

   typedef enum logic [2:0] {
      REG_AXIS_SELECT = 3'd0,
      REG_CENTER      = 3'd1,
      REG_WIDTH       = 3'd2,
      REG_BASE        = 3'd3,
      REG_PEAK        = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic        valid;
      logic        in_hump;
      logic [31:0] rem;
      logic [31:0] quo;
   } div_word_type;

   typedef struct packed {
      logic                          valid;
      logic                          in_hump;
      logic                          flip;
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
   } cordic_word_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] step);
      logic [31:0] a;
      case (step)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         5'd24:   a = 32'h00000029;
         5'd25:   a = 32'h00000014;
         5'd26:   a = 32'h0000000A;
         5'd27:   a = 32'h00000005;
         5'd28:   a = 32'h00000003;
         5'd29:   a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

[hdl/rchp_div_cell.sv]
`default_nettype none
module rchp_div_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic [30:0]          width,
   input  wire rchp_pkg::div_word_type word_in,
   output rchp_pkg::div_word_type    word_out
);
   rchp_pkg::div_word_type word_ff, word_in_nx;
   logic [32:0] rem2;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      rem2 = {word_in.rem, 1'b0};
      diff = rem2 - {2'b00, width};
      ge = rem2 >= {2'b00, width};
      word_in_nx = word_in;
      word_in_nx.rem = ge ? diff[31:0] : rem2[31:0];
      word_in_nx.quo = {word_in.quo[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff <= word_in_nx;
      end
   end

   assign word_out = word_ff;
endmodule
`default_nettype wire

[hdl/rchp_cordic_cell.sv]
`default_nettype none
module rchp_cordic_cell #(
   parameter int unsigned STEP = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire rchp_pkg::cordic_word_type word_in,
   output rchp_pkg::cordic_word_type    word_out
);
   rchp_pkg::cordic_word_type word_ff, word_in_nx;
   logic signed [rchp_pkg::CordicWidth-1:0] xs, ys, ang;

   always_comb begin
      xs = word_in.x >>> STEP;
      ys = word_in.y >>> STEP;
      ang = signed'({2'b00, rchp_pkg::atan_turns(5'(STEP))});
      word_in_nx = word_in;
      if (!word_in.z[rchp_pkg::CordicWidth-1]) begin
         word_in_nx.x = word_in.x - ys;
         word_in_nx.y = word_in.y + xs;
         word_in_nx.z = word_in.z - ang;
      end else begin
         word_in_nx.x = word_in.x + ys;
         word_in_nx.y = word_in.y - xs;
         word_in_nx.z = word_in.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff <= word_in_nx;
      end
   end

   assign word_out = word_ff;
endmodule
`default_nettype wire

[hdl/raised_cosine_hump_profile.sv]
// Raised-cosine hump profile: one point per cycle in, one result per point out, in order.
// Pipeline stages: window test, divider setup, 31 one-bit divider cells for the phase,
// 30 CORDIC cells, clamp, multiply, combine. Throughput is one point per clock; the whole
// pipeline holds while a result waits on rsp_stall. Write configuration only when idle.
`default_nettype none
module raised_cosine_hump_profile (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_coord_x,
   input  wire logic signed [31:0] req_coord_y,
   input  wire logic signed [31:0] req_coord_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_profile_value,
   output logic                    rsp_inside_hump,
   input  wire logic               csr_write_enable,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);
   localparam int unsigned CW = rchp_pkg::CordicWidth;

   logic [1:0]         axis_ff;
   logic signed [31:0] center_ff, base_ff, peak_ff;
   logic [30:0]        width_ff;
   logic [30:0]        w_eff;
   logic               adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= 2'd0;
         center_ff <= 32'sd0;
         width_ff  <= 31'd65536;
         base_ff   <= 32'sd0;
         peak_ff   <= 32'sd65536;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rchp_pkg::REG_AXIS_SELECT: axis_ff   <= csr_write_data[1:0];
            rchp_pkg::REG_CENTER:      center_ff <= signed'(csr_write_data);
            rchp_pkg::REG_WIDTH:       width_ff  <= csr_write_data[30:0];
            rchp_pkg::REG_BASE:        base_ff   <= signed'(csr_write_data);
            rchp_pkg::REG_PEAK:        peak_ff   <= signed'(csr_write_data);
            default: ;
         endcase
      end
   end

   assign w_eff = (width_ff == 31'd0) ? 31'd1 : width_ff;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // window test
   logic signed [31:0] sel;
   logic signed [33:0] d2, wn, ws;
   logic               s0_valid_ff, s0_inside_ff;
   logic [32:0]        s0_num_ff;
   logic signed [33:0] num_s;

   always_comb begin
      case (axis_ff)
         2'd0:    sel = req_coord_x;
         2'd1:    sel = req_coord_y;
         default: sel = req_coord_z;
      endcase
      ws = signed'({3'b000, w_eff});
      wn = -ws;
      d2 = (34'(sel) - 34'(center_ff)) <<< 1;
      num_s = d2 + ws;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_valid;
         s0_inside_ff <= (d2 >= wn) && (d2 <= ws);
         s0_num_ff    <= num_s[32:0];
      end
   end

   // integer part of the quotient, then one fraction bit per divider cell
   rchp_pkg::div_word_type div_w [0:rchp_pkg::DivCells];
   logic [32:0] w33, w2;
   logic        ge1, ge2;

   always_comb begin
      w33 = {2'b00, w_eff};
      w2  = {1'b0, w_eff, 1'b0};
      ge1 = s0_num_ff >= w33;
      ge2 = s0_num_ff >= w2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_w[0].valid <= 1'b0;
      end else if (adv) begin
         div_w[0].valid   <= s0_valid_ff;
         div_w[0].in_hump <= s0_inside_ff;
         div_w[0].rem     <= ge2 ? 32'(s0_num_ff - w2)
                           : (ge1 ? 32'(s0_num_ff - w33) : s0_num_ff[31:0]);
         div_w[0].quo     <= {31'd0, ge1 && !ge2};
      end
   end

   for (genvar g = 0; g < rchp_pkg::DivCells; g++) begin : g_div
      rchp_div_cell u_cell (
         .clock, .reset, .enable(adv), .width(w_eff),
         .word_in(div_w[g]), .word_out(div_w[g+1])
      );
   end

   // quadrant fold into cordic range, then the cordic cells
   rchp_pkg::cordic_word_type cor_w [0:rchp_pkg::CordicSteps];
   logic [31:0] phase, t;

   always_comb begin
      phase = div_w[rchp_pkg::DivCells].quo;
      cor_w[0].valid   = div_w[rchp_pkg::DivCells].valid;
      cor_w[0].in_hump = div_w[rchp_pkg::DivCells].in_hump;
      cor_w[0].flip    = phase[31] ^ phase[30];
      t = phase ^ {cor_w[0].flip, 31'd0};
      cor_w[0].x = signed'(rchp_pkg::CordicX0);
      cor_w[0].y = '0;
      cor_w[0].z = CW'(signed'(t));
   end

   for (genvar g = 0; g < rchp_pkg::CordicSteps; g++) begin : g_cordic
      rchp_cordic_cell #(.STEP(g)) u_cell (
         .clock, .reset, .enable(adv),
         .word_in(cor_w[g]), .word_out(cor_w[g+1])
      );
   end

   // clamp and sign
   logic               c_valid_ff, c_inside_ff;
   logic signed [31:0] c_ff;
   logic signed [CW-1:0] xc, xf;

   always_comb begin
      xf = cor_w[rchp_pkg::CordicSteps].x;
      if (xf > rchp_pkg::OneQ30)       xc = rchp_pkg::OneQ30;
      else if (xf < -rchp_pkg::OneQ30) xc = -rchp_pkg::OneQ30;
      else                             xc = xf;
      if (cor_w[rchp_pkg::CordicSteps].flip) xc = -xc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff  <= cor_w[rchp_pkg::CordicSteps].valid;
         c_inside_ff <= cor_w[rchp_pkg::CordicSteps].in_hump;
         c_ff        <= xc[31:0];
      end
   end

   // product
   logic               m_valid_ff, m_inside_ff;
   logic signed [64:0] m_prod_ff;
   logic signed [32:0] diff;

   assign diff = 33'(peak_ff) - 33'(base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff  <= c_valid_ff;
         m_inside_ff <= c_inside_ff;
         m_prod_ff   <= 65'(diff) * 65'(c_ff);
      end
   end

   // combine, round, saturate; base value outside the hump
   logic signed [32:0] sum;
   logic signed [65:0] v;
   logic signed [34:0] r;
   logic signed [31:0] res;
   logic               rsp_valid_ff, rsp_inside_ff;
   logic signed [31:0] rsp_value_ff;

   always_comb begin
      sum = 33'(peak_ff) + 33'(base_ff);
      v = (66'(sum) <<< 30) - 66'(m_prod_ff) + 66'sd1073741824;
      r = 35'(v >>> 31);
      if (r > 35'sd2147483647)       res = 32'h7FFFFFFF;
      else if (r < -35'sd2147483648) res = 32'h80000000;
      else                           res = r[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff  <= m_valid_ff;
         rsp_inside_ff <= m_inside_ff;
         rsp_value_ff  <= m_inside_ff ? res : base_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inside_hump   = rsp_inside_ff;
   assign rsp_profile_value = rsp_value_ff;
endmodule
`default_nettype wire

[hdl/rchp_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module rchp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_profile_value,
   input wire logic        rsp_inside_hump
);
   // a stalled word holds
   `RCHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_profile_value) && $stable(rsp_inside_hump))
   // input backs up only behind a waiting result
   `RCHP_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)
   // pipeline empty after reset
   `RCHP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)
endmodule

bind raised_cosine_hump_profile rchp_checker u_rchp_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_profile_value(rsp_profile_value),
   .rsp_inside_hump(rsp_inside_hump)
);
`default_nettype wire
